// ===== design/rv32s_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32s_pkg: shared types and constants of the RV32 subset core
// Opcodes, decoded operation record, result record and defaults.
// ----------------------------------------------------------------------------
package rv32s_pkg;

    localparam int DATA_WORDS_DEF = 4096;
    localparam int REG_COUNT_DEF  = 16;
    localparam int REG_IDX_W      = 5;    // holds any index up to 32 registers
    localparam int PIDX_W         = 12;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [6:0] OP_ADD    = 7'b0110011;
    localparam logic [6:0] OP_ADDI   = 7'b0010011;
    localparam logic [6:0] OP_LUI    = 7'b0110111;
    localparam logic [6:0] OP_LOAD   = 7'b0000011;
    localparam logic [6:0] OP_STORE  = 7'b0100011;
    localparam logic [6:0] OP_JALR   = 7'b1100111;
    localparam logic [6:0] OP_CUSTOM = 7'b1010101;
    localparam logic [6:0] OP_SYSTEM = 7'b1110011;

    localparam logic [2:0] F3_BYTE   = 3'd0;
    localparam logic [2:0] F3_WORD   = 3'd2;
    localparam logic [2:0] F3_BYTE_U = 3'd4;

    localparam logic [31:0] FB_BASE  = 32'h2000_0000;
    localparam logic [31:0] FB_LIMIT = 32'h2004_0000;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_HALT_SYS,
        ST_HALT_INV,
        ST_IGNORED
    } status_t;

    typedef enum logic [3:0] {
        K_ADD,
        K_ADDI,
        K_LUI,
        K_LW,
        K_LBU,
        K_SW,
        K_SB,
        K_JALR,
        K_NOP,
        K_HALT_SYS,
        K_HALT_INV,
        K_PRELOAD
    } kind_t;

    // decoded item, as it travels from the front end to the back end
    typedef struct packed {
        kind_t                 kind;
        logic [REG_IDX_W-1:0]  rd;
        logic [REG_IDX_W-1:0]  rs1;
        logic [REG_IDX_W-1:0]  rs2;
        logic [31:0]           imm;   // immediate, or preload data
        logic [PIDX_W-1:0]     pidx;
    } op_t;

    typedef struct packed {
        logic [31:0] next_pc;
        status_t     status;
        logic        fb_valid;
        logic [7:0]  fb_x;
        logic [7:0]  fb_y;
        logic [31:0] fb_pixel;
    } result_t;

endpackage

// ===== design/rv32s_front.sv =====
// ----------------------------------------------------------------------------
// rv32s_front: instruction classifier
// Splits an incoming item into kind, folded register indices and immediate.
// ----------------------------------------------------------------------------
module rv32s_front import rv32s_pkg::*; #(
    parameter int REG_COUNT = REG_COUNT_DEF
) (
    input  logic              cmd,
    input  logic [31:0]       instruction,
    input  logic [PIDX_W-1:0] preload_index,
    input  logic [31:0]       preload_data,
    output op_t               op
);

    logic [6:0]  opcode;
    logic [2:0]  funct3;
    logic [31:0] imm_i;
    logic [31:0] imm_s;

    // index field taken modulo REG_COUNT (a single subtraction, exact for REG_COUNT of 16 or more)
    function automatic logic [REG_IDX_W-1:0] fold(input logic [4:0] f);
        logic [5:0] t;
        t = {1'b0, f};
        if (t >= 6'(REG_COUNT)) begin
            t = t - 6'(REG_COUNT);
        end
        return t[REG_IDX_W-1:0];
    endfunction

    assign opcode = instruction[6:0];
    assign funct3 = instruction[14:12];
    assign imm_i  = {{20{instruction[31]}}, instruction[31:20]};
    assign imm_s  = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};

    always_comb begin
        op      = '0;
        op.rd   = fold(instruction[11:7]);
        op.rs1  = fold(instruction[19:15]);
        op.rs2  = fold(instruction[24:20]);
        op.pidx = preload_index;
        op.kind = K_NOP;
        if (cmd) begin
            op.kind = K_PRELOAD;
            op.imm  = preload_data;
        end else begin
            case (opcode)
                OP_ADD: begin
                    op.kind = K_ADD;
                end
                OP_ADDI: begin
                    op.kind = K_ADDI;
                    op.imm  = imm_i;
                end
                OP_LUI: begin
                    op.kind = K_LUI;
                    op.imm  = {instruction[31:12], 12'b0};
                end
                OP_LOAD: begin
                    op.imm = imm_i;
                    if (funct3 == F3_WORD) begin
                        op.kind = K_LW;
                    end else if (funct3 == F3_BYTE_U) begin
                        op.kind = K_LBU;
                    end else begin
                        op.kind = K_NOP;
                    end
                end
                OP_STORE: begin
                    op.imm = imm_s;
                    if (funct3 == F3_WORD) begin
                        op.kind = K_SW;
                    end else if (funct3 == F3_BYTE) begin
                        op.kind = K_SB;
                    end else begin
                        op.kind = K_NOP;
                    end
                end
                OP_JALR: begin
                    op.kind = K_JALR;
                    op.imm  = imm_i;
                end
                OP_CUSTOM, OP_SYSTEM: begin
                    op.kind = K_HALT_SYS;
                end
                default: begin
                    op.kind = K_HALT_INV;
                end
            endcase
        end
    end

endmodule

// ===== design/rv32s_queue.sv =====
// ----------------------------------------------------------------------------
// rv32s_queue: decoupling queue
// Small FIFO of decoded items between front end and back end.
// ----------------------------------------------------------------------------
module rv32s_queue import rv32s_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  pop_op,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = q_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== design/rv32s_back.sv =====
// ----------------------------------------------------------------------------
// rv32s_back: execution back end
// Register read, execute with data memory read, writeback and result register.
// ----------------------------------------------------------------------------
module rv32s_back import rv32s_pkg::*; #(
    parameter int DATA_WORDS = DATA_WORDS_DEF,
    parameter int REG_COUNT  = REG_COUNT_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    op_valid,
    input  op_t     op,
    output logic    pop,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam int RW = $clog2(REG_COUNT);
    localparam logic [31:0] WORDS_LIM = 32'(DATA_WORDS);

    typedef struct packed {
        kind_t       kind;
        logic [RW-1:0] rd;
        logic [31:0] value;     // rd value, or store / preload data
        logic [1:0]  lane;
        logic        in_range;
        logic [AW-1:0] widx;
        logic        reg_we;
        logic        mem_we;
        logic        halt;
        result_t     res;
    } wb_t;

    // register file: write-first read, valid bits give the reset value
    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg;
    logic                 rf_we;
    logic [RW-1:0]        rf_waddr, rf_ra1, rf_ra2;
    logic [31:0]          rf_wdata;
    logic [31:0]          rs1_data_reg, rs2_data_reg;

    // data memory
    logic [31:0]   dm_mem [DATA_WORDS];
    logic [AW-1:0] dm_raddr;
    logic [31:0]   dm_rdata_reg;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;

    // architectural state
    logic [31:0] pc_reg, pc_next;
    logic        halted_reg, halted_next;

    // stages
    logic    e_valid_reg, e_valid_next;
    op_t     e_op_reg;
    logic    w_valid_reg, w_valid_next;
    wb_t     w_reg, w_next;
    logic    w_done;
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg;

    // execute signals
    logic [31:0] opb, sum, pc4, load_val, sb_word;
    logic [7:0]  lane_byte;
    logic        word_ok, pre_ok, fb_hit, ignored;

    assign w_done = w_valid_reg && (!m_valid_reg || res_ready);
    // next item reads registers in the writeback cycle of the previous one
    assign pop    = op_valid && !e_valid_reg && (!w_valid_reg || w_done);
    assign rf_ra1 = op.rs1[RW-1:0];
    assign rf_ra2 = op.rs2[RW-1:0];

    // ---- execute ----
    assign opb     = (e_op_reg.kind == K_ADD) ? rs2_data_reg : e_op_reg.imm;
    assign sum     = rs1_data_reg + opb;
    assign pc4     = pc_reg + 32'd4;
    assign word_ok = ({2'b00, sum[31:2]} < WORDS_LIM);
    assign pre_ok  = (32'(e_op_reg.pidx) < WORDS_LIM);
    assign fb_hit  = (sum >= FB_BASE) && (sum < FB_LIMIT);
    assign ignored = halted_reg && (e_op_reg.kind != K_PRELOAD);
    assign dm_raddr = sum[AW+1:2];

    always_comb begin
        w_next              = '0;
        w_next.kind         = e_op_reg.kind;
        w_next.rd           = e_op_reg.rd[RW-1:0];
        w_next.lane         = sum[1:0];
        w_next.in_range     = word_ok;
        w_next.widx         = sum[AW+1:2];
        w_next.value        = rs2_data_reg;
        w_next.res.next_pc  = pc_reg;
        w_next.res.status   = ST_DONE;
        case (e_op_reg.kind)
            K_ADD, K_ADDI: begin
                w_next.reg_we      = 1'b1;
                w_next.value       = sum;
                w_next.res.next_pc = pc4;
            end
            K_LUI: begin
                w_next.reg_we      = 1'b1;
                w_next.value       = e_op_reg.imm;
                w_next.res.next_pc = pc4;
            end
            K_LW, K_LBU: begin
                w_next.reg_we      = 1'b1;
                w_next.res.next_pc = pc4;
            end
            K_SW: begin
                if (fb_hit) begin
                    w_next.res.fb_valid = 1'b1;
                    w_next.res.fb_x     = sum[9:2];
                    w_next.res.fb_y     = sum[17:10];
                    w_next.res.fb_pixel = rs2_data_reg;
                end else begin
                    w_next.mem_we = word_ok;
                end
                w_next.res.next_pc = pc4;
            end
            K_SB: begin
                w_next.mem_we      = word_ok;
                w_next.res.next_pc = pc4;
            end
            K_JALR: begin
                w_next.reg_we      = 1'b1;
                w_next.value       = pc4;
                w_next.res.next_pc = {sum[31:1], 1'b0};
            end
            K_HALT_SYS: begin
                w_next.halt       = 1'b1;
                w_next.res.status = ST_HALT_SYS;
            end
            K_HALT_INV: begin
                w_next.halt       = 1'b1;
                w_next.res.status = ST_HALT_INV;
            end
            K_PRELOAD: begin
                w_next.mem_we = pre_ok;
                w_next.widx   = AW'(e_op_reg.pidx);
                w_next.value  = e_op_reg.imm;
            end
            default: begin
                // unsupported load/store width: no effect, pc held
            end
        endcase
        if (ignored) begin
            w_next.reg_we      = 1'b0;
            w_next.mem_we      = 1'b0;
            w_next.halt        = 1'b0;
            w_next.res         = '0;
            w_next.res.next_pc = pc_reg;
            w_next.res.status  = ST_IGNORED;
        end
    end

    // ---- writeback ----
    assign lane_byte = dm_rdata_reg[{w_reg.lane, 3'b000} +: 8];

    always_comb begin
        load_val = '0;
        if (w_reg.in_range) begin
            load_val = (w_reg.kind == K_LBU) ? {24'b0, lane_byte & BYTE_MASK} : dm_rdata_reg;
        end
        sb_word = dm_rdata_reg;
        sb_word[{w_reg.lane, 3'b000} +: 8] = w_reg.value[7:0];
    end

    assign rf_we    = w_done && w_reg.reg_we && (w_reg.rd != '0);
    assign rf_waddr = w_reg.rd;
    assign rf_wdata = ((w_reg.kind == K_LW) || (w_reg.kind == K_LBU)) ? load_val : w_reg.value;
    assign dm_we    = w_done && w_reg.mem_we;
    assign dm_waddr = w_reg.widx;
    assign dm_wdata = (w_reg.kind == K_SB) ? sb_word : w_reg.value;

    always_comb begin
        e_valid_next = pop;
        w_valid_next = e_valid_reg ? 1'b1 : (w_valid_reg && !w_done);
        pc_next      = w_done ? w_reg.res.next_pc : pc_reg;
        halted_next  = halted_reg || (w_done && w_reg.halt);
        m_valid_next = w_done ? 1'b1 : (m_valid_reg && !res_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg  <= 1'b0;
            w_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= '0;
            halted_reg   <= 1'b0;
            rf_valid_reg <= '0;
        end else begin
            e_valid_reg <= e_valid_next;
            w_valid_reg <= w_valid_next;
            m_valid_reg <= m_valid_next;
            pc_reg      <= pc_next;
            halted_reg  <= halted_next;
            if (rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            e_op_reg <= op;
        end
        if (e_valid_reg) begin
            w_reg <= w_next;
        end
        if (w_done) begin
            m_res_reg <= w_reg.res;
        end
    end

    // register file ports
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        if (pop) begin
            if (rf_we && (rf_waddr == rf_ra1)) begin
                rs1_data_reg <= rf_wdata;
            end else begin
                rs1_data_reg <= rf_valid_reg[rf_ra1] ? rf_mem[rf_ra1] : '0;
            end
            if (rf_we && (rf_waddr == rf_ra2)) begin
                rs2_data_reg <= rf_wdata;
            end else begin
                rs2_data_reg <= rf_valid_reg[rf_ra2] ? rf_mem[rf_ra2] : '0;
            end
        end
    end

    // data memory ports
    always_ff @(posedge aclk) begin
        if (dm_we) begin
            dm_mem[dm_waddr] <= dm_wdata;
        end
        if (e_valid_reg) begin
            dm_rdata_reg <= dm_mem[dm_raddr];
        end
    end

    assign res_valid = m_valid_reg;
    assign res       = m_res_reg;

endmodule

// ===== design/rv32_subset_core_step.sv =====
// ----------------------------------------------------------------------------
// rv32_subset_core_step: minimal RV32 subset core, one instruction per item
// Front end decodes, a two-entry queue decouples, back end executes.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                               | tuser
//  --------+-----+--------------------------------------------------+--------------------
//  s_      | in  | instruction[31:0] preload_index[43:32]           | cmd[0]
//          |     | preload_data[75:44], zero pad to 80 bits         |
//  m_      | out | next_pc[31:0] fb_x[39:32] fb_y[47:40]            | status[1:0]
//          |     | fb_pixel[79:48]                                  | fb_valid[2]
//
//  The back end cannot take a new item before the one ahead of it reaches
//  writeback: the register read -> execute/memory read -> writeback loop holds
//  one item, and the next item reads the register file at the earliest in that
//  writeback cycle. Path: queue, register read, execute, writeback, result.
//  Reset clears pc, halted flag, register valid bits, queue and stage valids;
//  the data memory is not cleared.
//  A stalled m_ side holds writeback; the queue keeps s_tready up for two
//  more items meanwhile.
//
module rv32_subset_core_step import rv32s_pkg::*; #(
    parameter int DATA_WORDS = DATA_WORDS_DEF,
    parameter int REG_COUNT  = REG_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // instruction, preload_index, preload_data, pad
    input  logic [0:0]  s_tuser,   // cmd
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // next_pc, fb_x, fb_y, fb_pixel
    output logic [2:0]  m_tuser    // status, fb_valid
);

    op_t     dec_op;     // decoded incoming item
    op_t     q_op;       // head of the queue
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    in_xfer;    // input transfer this cycle
    result_t res;

    assign s_tready = !q_full;
    assign in_xfer  = s_tvalid && s_tready;

    // classify the item: kind, folded register indices, immediate
    rv32s_front #(
        .REG_COUNT (REG_COUNT)
    ) u_front (
        .cmd           (s_tuser[0]),
        .instruction   (s_tdata[31:0]),
        .preload_index (s_tdata[43:32]),
        .preload_data  (s_tdata[75:44]),
        .op            (dec_op)
    );

    // decouples acceptance from execution
    rv32s_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (in_xfer),
        .push_op (dec_op),
        .full    (q_full),
        .pop     (q_pop),
        .pop_op  (q_op),
        .empty   (q_empty)
    );

    // pc, register file, data memory, halted flag, result register
    rv32s_back #(
        .DATA_WORDS (DATA_WORDS),
        .REG_COUNT  (REG_COUNT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (!q_empty),
        .op        (q_op),
        .pop       (q_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.fb_pixel, res.fb_y, res.fb_x, res.next_pc};
    assign m_tuser = {res.fb_valid, res.status};

endmodule
